>>> design/clvu_pkg.sv
package clvu_pkg;

   // Sizes
   localparam int LEVELS_DEFAULT = 8;
   localparam int POS_W          = 32;
   localparam int RANGE_W        = 31;
   localparam int EXT_W          = 16;
   localparam int POFF_W         = 8;
   localparam int UPF_W          = 16;
   localparam int HEAD_W         = 16;
   localparam int QUO_W          = 15;
   localparam int MAG_W          = 40;
   localparam int NORM_W         = 30;
   localparam int SQ_W           = 64;
   localparam int ROOT_W         = 31;
   localparam int CNT_W          = 5;
   localparam int ROOT_STEPS     = 32;
   localparam int DIV_STEPS      = 15;

   // Fixed-point constants
   localparam logic [UPF_W-1:0] BUDGET_UNIT = 16'd256;
   localparam logic [EXT_W-1:0] EXT_ONE     = 16'd256;
   localparam logic [QUO_W-1:0] HEAD_ONE    = 15'd16384;

   // Configuration reset values
   localparam logic [EXT_W-1:0]  VOLUME_EXTENSION_RESET  = 16'd320;
   localparam logic [POFF_W-1:0] PREDICTION_OFFSET_RESET = 8'd102;
   localparam logic [UPF_W-1:0]  UPDATES_PER_FRAME_RESET = 16'd256;

   typedef enum logic [1:0] {
      CSR_VOLUME_EXTENSION  = 2'd0,
      CSR_PREDICTION_OFFSET = 2'd1,
      CSR_UPDATES_PER_FRAME = 2'd2,
      CSR_IGNORE_Z          = 2'd3
   } csr_index_type;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   typedef struct packed {
      logic [EXT_W-1:0]  volume_extension;
      logic [POFF_W-1:0] prediction_offset;
      logic [UPF_W-1:0]  updates_per_frame;
      logic              ignore_z;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SUM,
      S_NORM,
      S_SQUARE,
      S_ROOT,
      S_DIV_INIT,
      S_DIV_STEP,
      S_DIV_STORE,
      S_K_MUL,
      S_K_ROUND,
      S_OFFSET,
      S_BOX,
      S_PUBLISH
   } state_type;

   typedef struct packed {
      logic     load;
      logic     check;
      logic     sum;
      logic     norm;
      logic     square;
      logic     first;
      logic     root_step;
      logic     div_init;
      logic     div_step;
      logic     div_store;
      logic     k_mul;
      logic     k_round;
      logic     offset;
      logic     box;
      logic     out_load;
      axis_type axis;
   } cmd_type;

   typedef struct packed {
      logic exhausted;
      logic rebuild;
      logic norm_done;
      logic norm_zero;
   } status_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [POS_W-1:0] sat32(input logic signed [42:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -43'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/clvu_ctrl.sv
module clvu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  clvu_pkg::status_type   status,
   output clvu_pkg::cmd_type      cmd
);

   clvu_pkg::state_type                state_ff, state_in;
   logic [clvu_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   clvu_pkg::axis_type                 axis_ff, axis_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != clvu_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state, step counter and axis
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         clvu_pkg::S_IDLE: begin
            if (req_valid) state_in = clvu_pkg::S_CHECK;
         end
         clvu_pkg::S_CHECK: begin
            if (status.exhausted || !status.rebuild) state_in = clvu_pkg::S_PUBLISH;
            else state_in = clvu_pkg::S_SUM;
         end
         clvu_pkg::S_SUM: begin
            state_in = clvu_pkg::S_NORM;
         end
         clvu_pkg::S_NORM: begin
            if (status.norm_zero) begin
               state_in = clvu_pkg::S_K_MUL;
            end else if (status.norm_done) begin
               state_in = clvu_pkg::S_SQUARE;
               axis_in  = clvu_pkg::AXIS_X;
            end
         end
         clvu_pkg::S_SQUARE: begin
            if (axis_ff == clvu_pkg::AXIS_Z) begin
               state_in = clvu_pkg::S_ROOT;
               cnt_in   = '0;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         clvu_pkg::S_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == clvu_pkg::CNT_W'(clvu_pkg::ROOT_STEPS - 1)) begin
               state_in = clvu_pkg::S_DIV_INIT;
               axis_in  = clvu_pkg::AXIS_X;
            end
         end
         clvu_pkg::S_DIV_INIT: begin
            state_in = clvu_pkg::S_DIV_STEP;
            cnt_in   = '0;
         end
         clvu_pkg::S_DIV_STEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == clvu_pkg::CNT_W'(clvu_pkg::DIV_STEPS - 1)) begin
               state_in = clvu_pkg::S_DIV_STORE;
            end
         end
         clvu_pkg::S_DIV_STORE: begin
            if (axis_ff == clvu_pkg::AXIS_Z) begin
               state_in = clvu_pkg::S_K_MUL;
            end else begin
               state_in = clvu_pkg::S_DIV_INIT;
               axis_in  = axis_ff + 2'd1;
            end
         end
         clvu_pkg::S_K_MUL: begin
            state_in = clvu_pkg::S_K_ROUND;
         end
         clvu_pkg::S_K_ROUND: begin
            state_in = clvu_pkg::S_OFFSET;
            axis_in  = clvu_pkg::AXIS_X;
         end
         clvu_pkg::S_OFFSET: begin
            if (axis_ff == clvu_pkg::AXIS_Z) state_in = clvu_pkg::S_BOX;
            else axis_in = axis_ff + 2'd1;
         end
         clvu_pkg::S_BOX: begin
            state_in = clvu_pkg::S_PUBLISH;
         end
         clvu_pkg::S_PUBLISH: begin
            if (out_free) state_in = clvu_pkg::S_IDLE;
         end
         default: state_in = clvu_pkg::S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd      = '0;
      cmd.axis = axis_ff;
      unique case (state_ff)
         clvu_pkg::S_IDLE:      cmd.load      = req_valid;
         clvu_pkg::S_CHECK:     cmd.check     = 1'b1;
         clvu_pkg::S_SUM:       cmd.sum       = 1'b1;
         clvu_pkg::S_NORM:      cmd.norm      = 1'b1;
         clvu_pkg::S_SQUARE: begin
            cmd.square = 1'b1;
            cmd.first  = (axis_ff == clvu_pkg::AXIS_X);
         end
         clvu_pkg::S_ROOT:      cmd.root_step = 1'b1;
         clvu_pkg::S_DIV_INIT:  cmd.div_init  = 1'b1;
         clvu_pkg::S_DIV_STEP:  cmd.div_step  = 1'b1;
         clvu_pkg::S_DIV_STORE: cmd.div_store = 1'b1;
         clvu_pkg::S_K_MUL:     cmd.k_mul     = 1'b1;
         clvu_pkg::S_K_ROUND:   cmd.k_round   = 1'b1;
         clvu_pkg::S_OFFSET:    cmd.offset    = 1'b1;
         clvu_pkg::S_BOX:       cmd.box       = 1'b1;
         clvu_pkg::S_PUBLISH:   cmd.out_load  = out_free;
         default:               cmd           = '0;
      endcase
   end

   // Hold the result until taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clvu_pkg::S_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= clvu_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result not shown after load");
   a_publish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clvu_pkg::S_PUBLISH && rsp_valid_ff && rsp_stall)
      |=> state_ff == clvu_pkg::S_PUBLISH)
      else $error("result overwritten while stalled");
   a_check_after_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clvu_pkg::S_CHECK) |-> $past(state_ff) == clvu_pkg::S_IDLE)
      else $error("check entered without an item");
`endif

endmodule

>>> design/clvu_dp.sv
module clvu_dp #(
   parameter int LEVELS = clvu_pkg::LEVELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  clvu_pkg::cmd_type          cmd,
   output clvu_pkg::status_type       status,
   input  clvu_pkg::cfg_type          cfg,
   input  logic                       req_new_frame,
   input  logic [2:0]                 req_level_index,
   input  logic signed [31:0]         req_observer_x,
   input  logic signed [31:0]         req_observer_y,
   input  logic signed [31:0]         req_observer_z,
   input  logic [30:0]                req_visibility_range,
   input  logic                       req_force_update,
   output logic                       rsp_updated,
   output logic                       rsp_budget_exhausted,
   output logic signed [31:0]         rsp_min_x,
   output logic signed [31:0]         rsp_min_y,
   output logic signed [31:0]         rsp_min_z,
   output logic signed [31:0]         rsp_max_x,
   output logic signed [31:0]         rsp_max_y,
   output logic signed [31:0]         rsp_max_z
);

   localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int POS_W   = clvu_pkg::POS_W;
   localparam int MAG_W   = clvu_pkg::MAG_W;
   localparam int QUO_W   = clvu_pkg::QUO_W;
   localparam int SQ_W    = clvu_pkg::SQ_W;
   localparam int ROOT_W  = clvu_pkg::ROOT_W;

   // Item registers
   logic [LEVEL_W-1:0]          lv_ff, lv_in;
   logic signed [POS_W-1:0]     obs_ff [3];
   logic [30:0]                 range_ff;
   logic                        force_ff;

   // Per-level state
   logic signed [POS_W-1:0]     box_lo_ff [LEVELS][3];
   logic signed [POS_W-1:0]     box_hi_ff [LEVELS][3];
   logic signed [15:0]          head_ff   [LEVELS][3];
   logic signed [POS_W-1:0]     last_ff   [LEVELS][3];
   logic [15:0]                 budget_ff;
   logic                        exh_ff, upd_ff;

   // Heading arithmetic
   logic [MAG_W-1:0]            m_ff [3];
   logic                        sgn_ff [3];
   logic [SQ_W-1:0]             sq_ff, root_ff, bit_ff;
   logic [ROOT_W-1:0]           rem_ff;
   logic [QUO_W-1:0]            nlo_ff, quo_ff;
   logic [QUO_W-1:0]            nmag_ff [3];

   // Box arithmetic
   logic [46:0]                 p1_ff;
   logic                        kneg_ff;
   logic [38:0]                 kmag_ff;
   logic [39:0]                 amag_ff;
   logic signed [40:0]          off_ff [3];

   // Output registers
   logic                        upd_out_ff, exh_out_ff;
   logic signed [POS_W-1:0]     min_out_ff [3];
   logic signed [POS_W-1:0]     max_out_ff [3];

   // Combinational
   logic                        ok [3];
   logic                        contained;
   logic signed [40:0]          s_w [3];
   logic [MAG_W-1:0]            m_abs [3];
   logic [MAG_W-1:0]            m_or;
   logic                        any_hi8, any_hi1, all_lt21, all_lt29, all_zero;
   logic [MAG_W-1:0]            m_sel;
   logic [QUO_W-1:0]            nmag_sel;
   logic                        sgn_sel;
   logic [59:0]                 sq_prod;
   logic [SQ_W-1:0]             root_try;
   logic [ROOT_W-1:0]           len;
   logic [44:0]                 num;
   logic [ROOT_W:0]             div_try;
   logic [15:0]                 dmag;
   logic                        dneg;
   logic [55:0]                 kprod;
   logic [47:0]                 aprod;
   logic [54:0]                 oprod;
   logic [39:0]                 omag;
   logic signed [41:0]          c_w [3];
   logic signed [42:0]          lo_w [3];
   logic signed [42:0]          hi_w [3];

   // Fold the level index onto the levels present
   always_comb begin
      lv_in = '0;
      for (int k = 0; k < 8; k++) begin
         if (req_level_index == 3'(k)) lv_in = LEVEL_W'(k % LEVELS);
      end
   end

   // Containment test against the stored box
   always_comb begin
      logic signed [33:0] o, r, lo, hi;
      for (int i = 0; i < 3; i++) begin
         o     = 34'(obs_ff[i]);
         r     = $signed({3'b000, range_ff});
         lo    = 34'(box_lo_ff[lv_ff][i]);
         hi    = 34'(box_hi_ff[lv_ff][i]);
         ok[i] = (o - r >= lo) && (o + r <= hi);
      end
      contained = ok[0] && ok[1] && (ok[2] || cfg.ignore_z);
   end

   // Heading plus scaled movement, split into magnitude and sign
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_w[i]   = ((41'(obs_ff[i]) - 41'(last_ff[lv_ff][i])) <<< 6)
                    + 41'(head_ff[lv_ff][i]);
         m_abs[i] = s_w[i][40] ? MAG_W'(-s_w[i]) : MAG_W'(s_w[i]);
      end
   end

   // Range flags for the normalizing shift
   assign m_or     = m_ff[0] | m_ff[1] | m_ff[2];
   assign any_hi8  = |m_or[MAG_W-1:38];
   assign any_hi1  = |m_or[MAG_W-1:30];
   assign all_lt21 = ~|m_or[MAG_W-1:21];
   assign all_lt29 = ~|m_or[MAG_W-1:29];
   assign all_zero = ~|m_or;

   assign status.exhausted = (budget_ff < clvu_pkg::BUDGET_UNIT);
   assign status.rebuild   = force_ff || !contained;
   assign status.norm_done = !any_hi1 && !all_lt29;
   assign status.norm_zero = all_zero;

   // Axis select
   always_comb begin
      case (cmd.axis)
         clvu_pkg::AXIS_X: begin
            m_sel = m_ff[0]; nmag_sel = nmag_ff[0]; sgn_sel = sgn_ff[0];
         end
         clvu_pkg::AXIS_Y: begin
            m_sel = m_ff[1]; nmag_sel = nmag_ff[1]; sgn_sel = sgn_ff[1];
         end
         default: begin
            m_sel = m_ff[2]; nmag_sel = nmag_ff[2]; sgn_sel = sgn_ff[2];
         end
      endcase
   end

   assign sq_prod  = m_sel[29:0] * m_sel[29:0];
   assign root_try = root_ff + bit_ff;
   assign len      = root_ff[ROOT_W-1:0];
   assign num      = {1'b0, m_sel[29:0], 14'b0} + 45'(len[ROOT_W-1:1]);
   assign div_try  = {rem_ff, nlo_ff[QUO_W-1]};

   assign dneg  = (cfg.volume_extension < clvu_pkg::EXT_ONE);
   assign dmag  = dneg ? (clvu_pkg::EXT_ONE - cfg.volume_extension)
                       : (cfg.volume_extension - clvu_pkg::EXT_ONE);
   assign kprod = 56'(p1_ff) * 56'(cfg.prediction_offset) + 56'd32768;
   assign aprod = 48'(range_ff) * 48'(cfg.volume_extension) + 48'd128;
   assign oprod = 55'(kmag_ff) * 55'(nmag_sel) + 55'd8192;
   assign omag  = 40'(oprod >> 14);

   // New box bounds
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_w[i]  = 42'(obs_ff[i]) + 42'(off_ff[i]);
         lo_w[i] = 43'(c_w[i]) - $signed({3'b000, amag_ff});
         hi_w[i] = 43'(c_w[i]) + $signed({3'b000, amag_ff});
      end
   end

   // Item capture, budget and per-level state
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < 3; i++) begin
               box_lo_ff[l][i] <= '0;
               box_hi_ff[l][i] <= '0;
               head_ff[l][i]   <= '0;
               last_ff[l][i]   <= '0;
            end
         end
      end else begin
         if (cmd.load && req_new_frame) budget_ff <= cfg.updates_per_frame;
         if (cmd.box) begin
            budget_ff <= budget_ff - clvu_pkg::BUDGET_UNIT;
            for (int i = 0; i < 3; i++) begin
               box_lo_ff[lv_ff][i] <= clvu_pkg::sat32(lo_w[i]);
               box_hi_ff[lv_ff][i] <= clvu_pkg::sat32(hi_w[i]);
               head_ff[lv_ff][i]   <= sgn_ff[i] ? -16'(nmag_ff[i]) : 16'(nmag_ff[i]);
               last_ff[lv_ff][i]   <= obs_ff[i];
            end
         end
      end
   end

   // Arithmetic working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lv_ff     <= lv_in;
         obs_ff[0] <= req_observer_x;
         obs_ff[1] <= req_observer_y;
         obs_ff[2] <= req_observer_z;
         range_ff  <= req_visibility_range;
         force_ff  <= req_force_update;
         upd_ff    <= 1'b0;
      end
      if (cmd.check) exh_ff <= status.exhausted;
      if (cmd.sum) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i]    <= m_abs[i];
            sgn_ff[i]  <= s_w[i][40];
            nmag_ff[i] <= '0;
         end
      end
      // advance the normalizing shift
      if (cmd.norm) begin
         for (int i = 0; i < 3; i++) begin
            if (any_hi8)       m_ff[i] <= m_ff[i] >> 8;
            else if (any_hi1)  m_ff[i] <= m_ff[i] >> 1;
            else if (all_lt21) m_ff[i] <= m_ff[i] << 8;
            else if (all_lt29) m_ff[i] <= m_ff[i] << 1;
         end
      end
      // sum of squares, then prime the root
      if (cmd.square) begin
         if (cmd.first) begin
            sq_ff   <= SQ_W'(sq_prod);
            root_ff <= '0;
            bit_ff  <= SQ_W'(1) << 62;
         end else begin
            sq_ff <= sq_ff + SQ_W'(sq_prod);
         end
      end
      // one root digit a cycle
      if (cmd.root_step) begin
         if (sq_ff >= root_try) begin
            sq_ff   <= sq_ff - root_try;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      // one quotient bit a cycle
      if (cmd.div_init) begin
         rem_ff <= ROOT_W'(num[44:QUO_W]);
         nlo_ff <= num[QUO_W-1:0];
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         if (div_try >= {1'b0, len}) begin
            rem_ff <= ROOT_W'(div_try - {1'b0, len});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= div_try[ROOT_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         nlo_ff <= nlo_ff << 1;
      end
      if (cmd.div_store) begin
         nmag_ff[cmd.axis] <= (quo_ff > clvu_pkg::HEAD_ONE) ? clvu_pkg::HEAD_ONE : quo_ff;
      end
      if (cmd.k_mul) begin
         p1_ff   <= 47'(dmag) * 47'(range_ff);
         kneg_ff <= dneg;
      end
      if (cmd.k_round) begin
         kmag_ff <= 39'(kprod >> 16);
         amag_ff <= 40'(aprod >> 8);
      end
      if (cmd.offset) begin
         off_ff[cmd.axis] <= (kneg_ff ^ sgn_sel) ? -41'(omag) : 41'(omag);
      end
      if (cmd.box) upd_ff <= 1'b1;
      // capture the result
      if (cmd.out_load) begin
         upd_out_ff <= upd_ff;
         exh_out_ff <= exh_ff;
         for (int i = 0; i < 3; i++) begin
            min_out_ff[i] <= box_lo_ff[lv_ff][i];
            max_out_ff[i] <= box_hi_ff[lv_ff][i];
         end
      end
   end

   assign rsp_updated          = upd_out_ff;
   assign rsp_budget_exhausted = exh_out_ff;
   assign rsp_min_x            = min_out_ff[0];
   assign rsp_min_y            = min_out_ff[1];
   assign rsp_min_z            = min_out_ff[2];
   assign rsp_max_x            = max_out_ff[0];
   assign rsp_max_y            = max_out_ff[1];
   assign rsp_max_z            = max_out_ff[2];

`ifndef SYNTH
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.square && cmd.first) |-> (!any_hi1 && m_or[29]))
      else $error("squares taken before normalization finished");
   a_budget_spent: assert property (@(posedge clock) disable iff (reset)
      cmd.box |=> budget_ff == $past(budget_ff) - clvu_pkg::BUDGET_UNIT)
      else $error("budget not charged on rebuild");
   a_no_rebuild_exhausted: assert property (@(posedge clock) disable iff (reset)
      cmd.box |-> !exh_ff)
      else $error("rebuild with exhausted budget");
`endif

endmodule

>>> design/cascaded_lod_volume_update.sv
// Flow: when the budget is short or the cube is contained, the item goes from the check
//   straight to publish; a rebuild runs the normalizing shift, the 32-step square root
//   and three quotient passes (these are skipped for a zero heading sum), then the box.
// Items: one at a time; the next item is accepted once the result has moved into
//   the output register.
// Reset: synchronous; clears boxes, headings, last positions, budget; loads defaults.
module cascaded_lod_volume_update #(
   parameter int LEVELS = clvu_pkg::LEVELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_new_frame,
   input  logic [2:0]          req_level_index,
   input  logic signed [31:0]  req_observer_x,
   input  logic signed [31:0]  req_observer_y,
   input  logic signed [31:0]  req_observer_z,
   input  logic [30:0]         req_visibility_range,
   input  logic                req_force_update,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_updated,
   output logic                rsp_budget_exhausted,
   output logic signed [31:0]  rsp_min_x,
   output logic signed [31:0]  rsp_min_y,
   output logic signed [31:0]  rsp_min_z,
   output logic signed [31:0]  rsp_max_x,
   output logic signed [31:0]  rsp_max_y,
   output logic signed [31:0]  rsp_max_z,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);

   clvu_pkg::cfg_type     cfg_ff, cfg_in;
   clvu_pkg::cmd_type     cmd;
   clvu_pkg::status_type  status;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (clvu_pkg::csr_index_type'(csr_index))
            clvu_pkg::CSR_VOLUME_EXTENSION:  cfg_in.volume_extension  = csr_wdata;
            clvu_pkg::CSR_PREDICTION_OFFSET: cfg_in.prediction_offset = csr_wdata[7:0];
            clvu_pkg::CSR_UPDATES_PER_FRAME: cfg_in.updates_per_frame = csr_wdata;
            clvu_pkg::CSR_IGNORE_Z:          cfg_in.ignore_z          = csr_wdata[0];
            default:                         cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volume_extension  <= clvu_pkg::VOLUME_EXTENSION_RESET;
         cfg_ff.prediction_offset <= clvu_pkg::PREDICTION_OFFSET_RESET;
         cfg_ff.updates_per_frame <= clvu_pkg::UPDATES_PER_FRAME_RESET;
         cfg_ff.ignore_z          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clvu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   clvu_dp #(.LEVELS(LEVELS)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .cfg                  (cfg_ff),
      .req_new_frame        (req_new_frame),
      .req_level_index      (req_level_index),
      .req_observer_x       (req_observer_x),
      .req_observer_y       (req_observer_y),
      .req_observer_z       (req_observer_z),
      .req_visibility_range (req_visibility_range),
      .req_force_update     (req_force_update),
      .rsp_updated          (rsp_updated),
      .rsp_budget_exhausted (rsp_budget_exhausted),
      .rsp_min_x            (rsp_min_x),
      .rsp_min_y            (rsp_min_y),
      .rsp_min_z            (rsp_min_z),
      .rsp_max_x            (rsp_max_x),
      .rsp_max_y            (rsp_max_y),
      .rsp_max_z            (rsp_max_z)
   );

endmodule
